/* hw/rtl/gfcc_pkg.sv */
`timescale 1ns / 1ps

package gfcc_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_BITS   = $clog2(STORE_DEPTH);

    // footprint: centre and four corners
    localparam int NUM_POINTS = 5;
    localparam int PT_BITS    = $clog2(NUM_POINTS);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
    localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS     = 2'd2;

    // classified request handed from front to back
    typedef struct packed {
        logic                                  cmd;
        logic                                  occupied;
        logic [NUM_POINTS-1:0]                 use_pt;
        logic [NUM_POINTS-1:0][ADDR_BITS-1:0]  addr;
    } gfcc_entry_t;

endpackage

/* hw/rtl/grid_footprint_collision_check.sv */
`timescale 1ns / 1ps
// query path: s1, s2, the queue, cur_reg, rdata_reg, then done and hit; loads give no result
// throughput: a query uses five reads of the single-port occupancy memory, one load per cycle
// unless busy; results are strobed for one cycle and the receiver cannot stall
// reset: registers return to 256, 256, 128 and the occupancy memory is swept to open,
// one cell a cycle, so busy stays high after reset until every cell is cleared
module grid_footprint_collision_check (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cmd,
    input  logic [7:0]         cell_x,
    input  logic [7:0]         cell_z,
    input  logic               cell_occupied,
    input  logic signed [19:0] pos_x,
    input  logic signed [19:0] pos_z,
    input  logic signed [15:0] dir_x,
    input  logic signed [15:0] dir_z,
    input  logic [15:0]        step_speed,
    output logic               done,
    output logic               hit,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import gfcc_pkg::*;

    logic                 accept;
    logic [1:0]           inflight;
    logic                 push;
    gfcc_entry_t          push_entry;
    gfcc_entry_t          head;
    logic                 nonempty;
    logic                 pop;
    logic [QCNT_BITS-1:0] q_count;
    logic                 clearing;

    // room must exist for every request still in the front pipeline
    assign busy      = clearing ||
                       (32'(q_count) + 32'(inflight) >= QUEUE_DEPTH);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    gfcc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .cmd           (cmd),
        .cell_x        (cell_x),
        .cell_z        (cell_z),
        .cell_occupied (cell_occupied),
        .pos_x         (pos_x),
        .pos_z         (pos_z),
        .dir_x         (dir_x),
        .dir_z         (dir_z),
        .step_speed    (step_speed),
        .cfg_write     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .inflight      (inflight),
        .push          (push),
        .entry         (push_entry)
    );

    gfcc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .nonempty   (nonempty),
        .count      (q_count)
    );

    gfcc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .nonempty (nonempty),
        .pop      (pop),
        .clearing (clearing),
        .done     (done),
        .hit      (hit)
    );

endmodule

/* hw/rtl/gfcc_front.sv */
`timescale 1ns / 1ps

module gfcc_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic                    cmd,
    input  logic [7:0]              cell_x,
    input  logic [7:0]              cell_z,
    input  logic                    cell_occupied,
    input  logic signed [19:0]      pos_x,
    input  logic signed [19:0]      pos_z,
    input  logic signed [15:0]      dir_x,
    input  logic signed [15:0]      dir_z,
    input  logic [15:0]             step_speed,
    input  logic                    cfg_write,
    input  logic [1:0]              cfg_index,
    input  logic [15:0]             cfg_data,
    output logic [1:0]              inflight,
    output logic                    push,
    output gfcc_pkg::gfcc_entry_t   entry
);
    import gfcc_pkg::*;

    localparam int CELL_BITS = 14;
    localparam int EXT_BITS  = 22;

    logic [8:0]  map_width_reg;
    logic [8:0]  map_height_reg;
    logic [15:0] radius_reg;

    logic               s1_v_reg;
    logic               s1_cmd_reg;
    logic               s1_occ_reg;
    logic [7:0]         s1_cx_reg;
    logic [7:0]         s1_cz_reg;
    logic signed [19:0] s1_px_reg;
    logic signed [19:0] s1_pz_reg;
    logic signed [31:0] s1_prod_x_reg;
    logic signed [31:0] s1_prod_z_reg;

    logic               s2_v_reg;
    logic               s2_cmd_reg;
    logic               s2_occ_reg;
    logic [7:0]         s2_cx_reg;
    logic [7:0]         s2_cz_reg;
    logic signed [20:0] s2_fx_reg;
    logic signed [20:0] s2_fz_reg;

    logic signed [31:0] prod_x_next;
    logic signed [31:0] prod_z_next;
    logic signed [20:0] fx_next;
    logic signed [20:0] fz_next;

    logic [CELL_BITS-2:0] eff_w;
    logic [CELL_BITS-2:0] eff_h;

    logic signed [EXT_BITS-1:0] rad;
    logic [CELL_BITS-1:0]  gx [3];
    logic [CELL_BITS-1:0]  gz [3];
    logic [2:0]            okx;
    logic [2:0]            okz;

    function automatic logic [CELL_BITS-1:0] to_cell(input logic signed [EXT_BITS-1:0] v);
        logic signed [EXT_BITS-1:0] s;
        begin
            s = v >>> 8;
            return s[CELL_BITS-1:0];
        end
    endfunction

    function automatic logic cell_ok(input logic [CELL_BITS-1:0] c,
                                     input logic [CELL_BITS-2:0] lim);
        return !c[CELL_BITS-1] && (c[CELL_BITS-2:0] < lim);
    endfunction

    function automatic logic [ADDR_BITS-1:0] cell_addr(input logic [CELL_BITS-2:0] x,
                                                       input logic [CELL_BITS-2:0] z);
        return ADDR_BITS'(z * MAX_WIDTH + x);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= 9'd256;
            map_height_reg <= 9'd256;
            radius_reg     <= 16'd128;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MAP_WIDTH:  map_width_reg  <= cfg_data[8:0];
                REG_MAP_HEIGHT: map_height_reg <= cfg_data[8:0];
                REG_RADIUS:     radius_reg     <= cfg_data;
                default:        ;
            endcase
        end
    end

    // signed direction times unsigned speed, exact in 32 bits
    assign prod_x_next = $signed({{16{dir_x[15]}}, dir_x}) * $signed({16'd0, step_speed});
    assign prod_z_next = $signed({{16{dir_z[15]}}, dir_z}) * $signed({16'd0, step_speed});

    assign fx_next = 21'(s1_px_reg) + 21'(s1_prod_x_reg >>> 14);
    assign fz_next = 21'(s1_pz_reg) + 21'(s1_prod_z_reg >>> 14);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= accept;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg    <= cmd;
            s1_occ_reg    <= cell_occupied;
            s1_cx_reg     <= cell_x;
            s1_cz_reg     <= cell_z;
            s1_px_reg     <= pos_x;
            s1_pz_reg     <= pos_z;
            s1_prod_x_reg <= prod_x_next;
            s1_prod_z_reg <= prod_z_next;
        end
        if (s1_v_reg)
        begin
            s2_cmd_reg <= s1_cmd_reg;
            s2_occ_reg <= s1_occ_reg;
            s2_cx_reg  <= s1_cx_reg;
            s2_cz_reg  <= s1_cz_reg;
            s2_fx_reg  <= fx_next;
            s2_fz_reg  <= fz_next;
        end
    end

    // effective map size, never beyond the store
    assign eff_w = (13'(map_width_reg) < 13'(MAX_WIDTH)) ? 13'(map_width_reg) : 13'(MAX_WIDTH);
    assign eff_h = (13'(map_height_reg) < 13'(MAX_HEIGHT)) ? 13'(map_height_reg)
                                                          : 13'(MAX_HEIGHT);

    assign rad = $signed({6'd0, radius_reg});

    // index 0 centre, 1 minus radius, 2 plus radius
    always_comb
    begin
        gx[0] = to_cell(22'(s2_fx_reg));
        gx[1] = to_cell(22'(s2_fx_reg) - rad);
        gx[2] = to_cell(22'(s2_fx_reg) + rad);
        gz[0] = to_cell(22'(s2_fz_reg));
        gz[1] = to_cell(22'(s2_fz_reg) - rad);
        gz[2] = to_cell(22'(s2_fz_reg) + rad);
        for (int i = 0; i < 3; i++)
        begin
            okx[i] = cell_ok(gx[i], eff_w);
            okz[i] = cell_ok(gz[i], eff_h);
        end
    end

    always_comb
    begin
        entry.cmd      = s2_cmd_reg;
        entry.occupied = s2_occ_reg;
        if (s2_cmd_reg == CMD_LOAD)
        begin
            entry.use_pt  = '0;
            entry.addr    = '0;
            entry.use_pt[0] = (13'(s2_cx_reg) < eff_w) && (13'(s2_cz_reg) < eff_h);
            entry.addr[0]   = cell_addr(13'(s2_cx_reg), 13'(s2_cz_reg));
        end
        else
        begin
            entry.use_pt[0] = okx[0] && okz[0];
            entry.use_pt[1] = okx[1] && okz[1];
            entry.use_pt[2] = okx[1] && okz[2];
            entry.use_pt[3] = okx[2] && okz[1];
            entry.use_pt[4] = okx[2] && okz[2];
            entry.addr[0]   = cell_addr(gx[0][CELL_BITS-2:0], gz[0][CELL_BITS-2:0]);
            entry.addr[1]   = cell_addr(gx[1][CELL_BITS-2:0], gz[1][CELL_BITS-2:0]);
            entry.addr[2]   = cell_addr(gx[1][CELL_BITS-2:0], gz[2][CELL_BITS-2:0]);
            entry.addr[3]   = cell_addr(gx[2][CELL_BITS-2:0], gz[1][CELL_BITS-2:0]);
            entry.addr[4]   = cell_addr(gx[2][CELL_BITS-2:0], gz[2][CELL_BITS-2:0]);
        end
    end

    assign push     = s2_v_reg;
    assign inflight = {1'b0, s1_v_reg} + {1'b0, s2_v_reg};

endmodule

/* hw/rtl/gfcc_queue.sv */
`timescale 1ns / 1ps

module gfcc_queue (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  gfcc_pkg::gfcc_entry_t           push_entry,
    input  logic                            pop,
    output gfcc_pkg::gfcc_entry_t           head,
    output logic                            nonempty,
    output logic [gfcc_pkg::QCNT_BITS-1:0]  count
);
    import gfcc_pkg::*;

    gfcc_entry_t          slots_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg;
    logic                 do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= QPTR_BITS'(32'(wr_ptr_reg) + 1 == QUEUE_DEPTH ? 0
                                                                 : 32'(wr_ptr_reg) + 1);
            if (do_pop)
                rd_ptr_reg <= QPTR_BITS'(32'(rd_ptr_reg) + 1 == QUEUE_DEPTH ? 0
                                                                 : 32'(rd_ptr_reg) + 1);
            if (push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (!push && do_pop)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

    assign head     = slots_reg[rd_ptr_reg];
    assign nonempty = (count_reg != '0);
    assign count    = count_reg;

endmodule

/* hw/rtl/gfcc_back.sv */
`timescale 1ns / 1ps

module gfcc_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  gfcc_pkg::gfcc_entry_t   head,
    input  logic                    nonempty,
    output logic                    pop,
    output logic                    clearing,
    output logic                    done,
    output logic                    hit
);
    import gfcc_pkg::*;

    logic                 store [STORE_DEPTH];
    logic                 rdata_reg;

    logic                 clear_reg;
    logic [ADDR_BITS-1:0] clr_addr_reg;

    gfcc_entry_t          cur_reg;
    logic                 cur_v_reg;
    logic [PT_BITS-1:0]   pt_reg;

    logic                 rd_v_reg;
    logic                 rd_use_reg;
    logic                 rd_first_reg;
    logic                 rd_last_reg;
    logic                 acc_reg;
    logic                 done_reg;
    logic                 hit_reg;

    logic                 finishing;
    logic                 do_read;
    logic                 do_write;
    logic [ADDR_BITS-1:0] op_addr;
    logic                 acc_next;

    assign finishing = cur_v_reg &&
                       ((cur_reg.cmd == CMD_LOAD) || (32'(pt_reg) == NUM_POINTS - 1));
    assign pop       = !clear_reg && nonempty && (!cur_v_reg || finishing);
    assign do_read   = cur_v_reg && (cur_reg.cmd == CMD_QUERY);
    assign do_write  = cur_v_reg && (cur_reg.cmd == CMD_LOAD) && cur_reg.use_pt[0];
    assign op_addr   = do_read ? cur_reg.addr[pt_reg] : cur_reg.addr[0];

    // single port: a clearing write, a load write or one footprint read per cycle
    always_ff @(posedge clk)
    begin
        if (clear_reg)
            store[clr_addr_reg] <= 1'b0;
        else if (do_write)
            store[op_addr] <= cur_reg.occupied;
        else if (do_read)
            rdata_reg <= store[op_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg    <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clear_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (32'(clr_addr_reg) == STORE_DEPTH - 1)
                clear_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_v_reg <= 1'b0;
            pt_reg    <= '0;
        end
        else if (pop)
        begin
            cur_v_reg <= 1'b1;
            pt_reg    <= '0;
        end
        else if (finishing)
            cur_v_reg <= 1'b0;
        else if (cur_v_reg)
            pt_reg <= pt_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head;
    end

    assign acc_next = (rd_first_reg ? 1'b0 : acc_reg) | (rd_use_reg & rdata_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg     <= 1'b0;
            rd_use_reg   <= 1'b0;
            rd_first_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
            acc_reg      <= 1'b0;
            done_reg     <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            rd_v_reg     <= do_read;
            rd_use_reg   <= cur_reg.use_pt[pt_reg];
            rd_first_reg <= (pt_reg == '0);
            rd_last_reg  <= (32'(pt_reg) == NUM_POINTS - 1);
            done_reg     <= rd_v_reg && rd_last_reg;
            if (rd_v_reg)
                acc_reg <= acc_next;
            if (rd_v_reg && rd_last_reg)
                hit_reg <= acc_next;
        end
    end

    assign clearing = clear_reg;
    assign done     = done_reg;
    assign hit      = hit_reg;

endmodule
